// ===== sv/hcd_pkg.sv =====
// Shared types, constants and the cosine table for the hill car dynamics step.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcd_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int COS_TABLE_ENTRIES = 256;
  localparam int COS_IDX_BITS      = $clog2(COS_TABLE_ENTRIES);

  localparam int POS_W  = FRAC_BITS + 2;
  localparam int VEL_W  = POS_W + 1;
  localparam int SPD_W  = POS_W - 1;
  localparam int MUL_BW = 32;
  localparam int PROD_W = POS_W + MUL_BW + 1;

  typedef logic signed [POS_W-1:0]  hcd_pos_t;
  typedef logic signed [VEL_W-1:0]  hcd_vel_t;
  typedef logic signed [PROD_W-1:0] hcd_prod_t;
  typedef logic [SPD_W-1:0]         hcd_spd_t;
  typedef hcd_pos_t hcd_cos_tbl_t [COS_TABLE_ENTRIES];

  // 3 / (2 pi) as a Q32 turn, and gravity / push scale factors in Q32
  localparam logic [MUL_BW-1:0] PHASE_K  = 32'd2050695827;
  localparam logic [MUL_BW-1:0] GRAV_Q32 = 32'd10737418;
  localparam logic [63:0]       PUSH_Q32 = 64'd4294967;

  localparam hcd_vel_t PUSH =
    VEL_W'((PUSH_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam hcd_prod_t GRAV_RND = PROD_W'(64'h8000_0000);
  localparam hcd_pos_t  POS_INIT = -POS_W'(1 << (FRAC_BITS - 1));
  localparam hcd_pos_t  COS_ONE  = POS_W'(1 << FRAC_BITS);

  localparam hcd_spd_t RST_MAX_SPEED   = SPD_W'(4588);
  localparam hcd_pos_t RST_LOWER_BOUND = -POS_W'(78643);
  localparam hcd_pos_t RST_UPPER_BOUND = POS_W'(39322);
  localparam hcd_pos_t RST_GOAL_LEVEL  = POS_W'(32768);

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED   = 2'd0,
    CFG_LOWER_BOUND = 2'd1,
    CFG_UPPER_BOUND = 2'd2,
    CFG_GOAL_LEVEL  = 2'd3
  } hcd_cfg_idx_t;

  typedef enum logic {
    REQ_STEP    = 1'b0,
    REQ_RESTART = 1'b1
  } hcd_req_type_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_X_NEG = 3'd1,
    ACT_X_POS = 3'd2,
    ACT_Y_NEG = 3'd3,
    ACT_Y_POS = 3'd4
  } hcd_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X_PH,
    ST_X_COS,
    ST_X_GRAV,
    ST_X_ACC,
    ST_Y_PH,
    ST_Y_COS,
    ST_Y_GRAV,
    ST_Y_ACC,
    ST_X_VCL,
    ST_X_PCL,
    ST_Y_VCL,
    ST_Y_PCL,
    ST_DONE
  } hcd_state_t;

  typedef struct packed {
    logic ready;
    logic restart;
    logic axis_y;
    logic mul_grav;
    logic cos_ld;
    logic acc_ld;
    logic vclamp;
    logic pclamp;
    logic out_ld;
  } hcd_ctrl_t;

  // cos(2 pi i / N): fold to a quarter turn, Horner series to x^10 in Q30
  function automatic hcd_cos_tbl_t build_cos_tbl();
    hcd_cos_tbl_t       tbl;
    logic [63:0]        f;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] c;
    logic signed [63:0] r;
    logic               neg;
    for (int i = 0; i < COS_TABLE_ENTRIES; i++) begin
      f   = 64'(i) << (32 - COS_IDX_BITS);
      neg = 1'b0;
      if (f > 64'h8000_0000) f = 64'h1_0000_0000 - f;
      if (f > 64'h4000_0000) begin
        f   = 64'h8000_0000 - f;
        neg = 1'b1;
      end
      x  = (f * 64'd6746518852) >> 32;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd90;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd56;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd30;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd12;
      c  = 64'sd1073741824 - $signed(((x2 * t) >> 30) / 64'd2);
      if (c < 0) c = 64'sd0;
      r  = (c + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      tbl[i] = neg ? POS_W'(-r) : POS_W'(r);
    end
    return tbl;
  endfunction

  localparam hcd_cos_tbl_t COS_TBL = build_cos_tbl();

endpackage

`default_nettype wire

// ===== sv/hcd_ifs.sv =====
// Valid/ready channel interfaces: step requests in, state results out.
// Depends on hcd_pkg for field widths.
`default_nettype none

interface hcd_req_if import hcd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] action;

  modport source (output valid, req_type, action, input ready);
  modport sink   (input valid, req_type, action, output ready);
endinterface

interface hcd_rsp_if import hcd_pkg::*; ();
  logic     valid;
  logic     ready;
  hcd_pos_t pos_x;
  hcd_pos_t pos_y;
  hcd_pos_t vel_x;
  hcd_pos_t vel_y;
  logic     at_goal;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, at_goal, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, at_goal, output ready);
endinterface

`default_nettype wire

// ===== sv/hcd_mul.sv =====
// Shared signed multiplier with registered product (phase and gravity scaling).
// Depends on hcd_pkg.
`default_nettype none

module hcd_mul import hcd_pkg::*; (
  input  wire logic              clk,
  input  wire hcd_pos_t          a,
  input  wire logic [MUL_BW-1:0] b,
  output hcd_prod_t              prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a * $signed({1'b0, b}));
  end

endmodule

`default_nettype wire

// ===== sv/hcd_seq.sv =====
// Step sequencer: walks both axes through phase, cosine, gravity, update, clamps.
// Depends on hcd_pkg; drives hcd_ctrl_t into the datapath.
`default_nettype none

module hcd_seq import hcd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_type,
  input  wire logic act_ok,
  input  wire logic out_free,
  output hcd_ctrl_t ctrl
);

  hcd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_type == REQ_RESTART) state_next = ST_DONE;
          else if (act_ok)             state_next = ST_X_PH;
          else                         state_next = ST_X_VCL;
        end
      end
      ST_X_PH:   state_next = ST_X_COS;
      ST_X_COS:  state_next = ST_X_GRAV;
      ST_X_GRAV: state_next = ST_X_ACC;
      ST_X_ACC:  state_next = ST_Y_PH;
      ST_Y_PH:   state_next = ST_Y_COS;
      ST_Y_COS:  state_next = ST_Y_GRAV;
      ST_Y_GRAV: state_next = ST_Y_ACC;
      ST_Y_ACC:  state_next = ST_X_VCL;
      ST_X_VCL:  state_next = ST_X_PCL;
      ST_X_PCL:  state_next = ST_Y_VCL;
      ST_Y_VCL:  state_next = ST_Y_PCL;
      ST_Y_PCL:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.ready    = (state == ST_IDLE);
    ctrl.restart  = (state == ST_IDLE) && req_valid && (req_type == REQ_RESTART);
    ctrl.axis_y   = (state == ST_Y_PH) || (state == ST_Y_COS) || (state == ST_Y_GRAV) ||
                    (state == ST_Y_ACC) || (state == ST_Y_VCL) || (state == ST_Y_PCL);
    ctrl.mul_grav = (state == ST_X_GRAV) || (state == ST_Y_GRAV);
    ctrl.cos_ld   = (state == ST_X_COS) || (state == ST_Y_COS);
    ctrl.acc_ld   = (state == ST_X_ACC) || (state == ST_Y_ACC);
    ctrl.vclamp   = (state == ST_X_VCL) || (state == ST_Y_VCL);
    ctrl.pclamp   = (state == ST_X_PCL) || (state == ST_Y_PCL);
    ctrl.out_ld   = (state == ST_DONE) && out_free;
  end

endmodule

`default_nettype wire

// ===== sv/two_axis_hill_car_dynamics_step.sv =====
// Two-axis hill car dynamics step: top level with state, config and datapath.
// Depends on hcd_pkg, hcd_ifs, hcd_mul and hcd_seq.
//
// Usage:
//   req channel: one beat per request, req_type 0 = step with action 0..4
//   (none, -x, +x, -y, +y; 5..7 skip push and gravity), 1 = restart at -0.5.
//   rsp channel: one beat per request with both positions, both velocities
//   and at_goal; positions and velocities are Q1.16 signed.
//   cfg port: cfg_we/cfg_idx/cfg_wdata writes max_speed, lower_bound,
//   upper_bound, goal_level; write only while no request is in flight.
// Sequence:
//   A step holds the block from the accept cycle in idle through the
//   sequencer states (per axis: phase multiply, table read, gravity
//   multiply and velocity update; then per axis: velocity and position
//   clamp) to the done state, which loads the output register, the source
//   of its result beat. An unknown action skips the acceleration states
//   and a restart goes straight to done; the single multiplier is shared.
//   req.ready is high only in idle; it stays high while a result waits.
// Reset: synchronous rst restores the start state and register defaults.
// Stall: a held result parks the sequencer in its final cycle until taken.
`default_nettype none

module two_axis_hill_car_dynamics_step import hcd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [POS_W-1:0]     cfg_wdata,
  hcd_req_if.sink                   req,
  hcd_rsp_if.source                 rsp
);

  hcd_ctrl_t ctrl;

  hcd_spd_t max_speed;
  hcd_pos_t lower_bound;
  hcd_pos_t upper_bound;
  hcd_pos_t goal_level;

  hcd_pos_t x_pos, y_pos;
  hcd_vel_t x_vel, y_vel;
  logic [2:0] act;
  hcd_pos_t   cos_r;
  hcd_prod_t  prod;
  logic       rsp_valid;

  hcd_pos_t          mul_a;
  logic [MUL_BW-1:0] mul_b;
  hcd_pos_t          pos_sel;
  hcd_vel_t          vel_sel;
  hcd_pos_t          cos_mag;
  hcd_prod_t         g_sum;
  hcd_vel_t          grav;
  hcd_vel_t          dv;
  hcd_vel_t          vel_acc;
  hcd_vel_t          lim;
  hcd_vel_t          vel_cl;
  hcd_vel_t          p_sum;
  hcd_vel_t          p_up;
  hcd_vel_t          p_cl;
  hcd_vel_t          lb_w;
  hcd_vel_t          ub_w;
  logic              vel_zero;
  logic              out_free;
  logic              act_ok;

  assign act_ok   = (req.action <= ACT_Y_POS);
  assign out_free = !rsp_valid || rsp.ready;

  hcd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .act_ok    (act_ok),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  assign req.ready = ctrl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed   <= RST_MAX_SPEED;
      lower_bound <= RST_LOWER_BOUND;
      upper_bound <= RST_UPPER_BOUND;
      goal_level  <= RST_GOAL_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_SPEED:   max_speed   <= cfg_wdata[SPD_W-1:0];
        CFG_LOWER_BOUND: lower_bound <= cfg_wdata;
        CFG_UPPER_BOUND: upper_bound <= cfg_wdata;
        CFG_GOAL_LEVEL:  goal_level  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // axis operand selection and shared multiplier
  assign pos_sel = ctrl.axis_y ? y_pos : x_pos;
  assign vel_sel = ctrl.axis_y ? y_vel : x_vel;
  assign cos_mag = cos_r[POS_W-1] ? -cos_r : cos_r;
  assign mul_a   = ctrl.mul_grav ? cos_mag : pos_sel;
  assign mul_b   = ctrl.mul_grav ? GRAV_Q32 : PHASE_K;

  hcd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (ctrl.cos_ld) begin
      cos_r <= COS_TBL[prod[FRAC_BITS+31 -: COS_IDX_BITS]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act <= req.action;
    end
  end

  // velocity update: push minus signed gravity
  assign g_sum = prod + GRAV_RND;
  assign grav  = VEL_W'(g_sum[POS_W+31:32]);

  always_comb begin
    dv = '0;
    case (act)
      ACT_X_NEG: if (!ctrl.axis_y) dv = -PUSH;
      ACT_X_POS: if (!ctrl.axis_y) dv = PUSH;
      ACT_Y_NEG: if (ctrl.axis_y)  dv = -PUSH;
      ACT_Y_POS: if (ctrl.axis_y)  dv = PUSH;
      default:   dv = '0;
    endcase
  end

  assign vel_acc = cos_r[POS_W-1] ? (vel_sel + dv + grav) : (vel_sel + dv - grav);

  // clamps
  assign lim    = VEL_W'({1'b0, max_speed});
  assign vel_cl = (vel_sel > lim) ? lim : ((vel_sel < -lim) ? -lim : vel_sel);
  assign lb_w   = VEL_W'(lower_bound);
  assign ub_w   = VEL_W'(upper_bound);
  assign p_sum  = VEL_W'(pos_sel) + vel_sel;
  assign p_up   = (p_sum > ub_w) ? ub_w : p_sum;
  assign p_cl   = (p_up < lb_w) ? lb_w : p_up;
  assign vel_zero = ((p_cl == ub_w) && (vel_sel > 0)) || ((p_cl == lb_w) && (vel_sel < 0));

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      x_pos <= POS_INIT;
      y_pos <= POS_INIT;
      x_vel <= '0;
      y_vel <= '0;
    end else if (ctrl.acc_ld) begin
      if (ctrl.axis_y) y_vel <= vel_acc;
      else             x_vel <= vel_acc;
    end else if (ctrl.vclamp) begin
      if (ctrl.axis_y) y_vel <= vel_cl;
      else             x_vel <= vel_cl;
    end else if (ctrl.pclamp) begin
      if (ctrl.axis_y) begin
        y_pos <= POS_W'(p_cl);
        if (vel_zero) y_vel <= '0;
      end else begin
        x_pos <= POS_W'(p_cl);
        if (vel_zero) x_vel <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      rsp.pos_x   <= x_pos;
      rsp.pos_y   <= y_pos;
      rsp.vel_x   <= POS_W'(x_vel);
      rsp.vel_y   <= POS_W'(y_vel);
      rsp.at_goal <= (x_pos >= goal_level) && (y_pos >= goal_level);
    end
  end

  assign rsp.valid = rsp_valid;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while a step was in flight");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_ld |=> rsp.valid)
    else $error("result load did not raise rsp.valid");

  a_one_datapath_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.cos_ld, ctrl.acc_ld, ctrl.vclamp, ctrl.pclamp, ctrl.out_ld}))
    else $error("overlapping datapath operations");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.cos_ld |=> ((cos_r <= COS_ONE) && (cos_r >= -COS_ONE)))
    else $error("cosine table value out of range");
`endif

endmodule

`default_nettype wire

// ===== test/two_axis_hill_car_dynamics_step_tb.sv =====
`timescale 1ns / 1ps
// Testbench for two_axis_hill_car_dynamics_step: directed and random step and
// restart beats across register settings, checked against a fixed-point car model.
// Depends on hcd_pkg, hcd_ifs and the block's RTL.

module two_axis_hill_car_dynamics_step_tb;
  import hcd_pkg::*;

  localparam int          FB         = 16;
  localparam int          COS_N      = 256;
  localparam logic [63:0] TURN_K     = 64'd2050695827;
  localparam logic [63:0] TWO_PI_30  = 64'd6746518852;
  localparam logic [63:0] ONE_30     = 64'd1073741824;
  localparam logic [63:0] PUSH_32    = 64'd4294967;
  localparam logic [63:0] GRAV_32    = 64'd10737418;
  localparam logic [2:0]  ACT_BAD_LO = 3'd5;
  localparam logic [2:0]  ACT_BAD_HI = 3'd7;

  typedef struct packed {
    hcd_req_type_t kind;
    logic [2:0]    act;
  } car_req_t;

  typedef struct packed {
    hcd_pos_t pos_x;
    hcd_pos_t pos_y;
    hcd_pos_t vel_x;
    hcd_pos_t vel_y;
    logic     at_goal;
  } car_state_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POS_W-1:0]     cfg_wdata;

  hcd_req_if req_bus();
  hcd_rsp_if rsp_bus();

  two_axis_hill_car_dynamics_step u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  car_req_t   pending_reqs[$];
  car_state_t expected_states[$];
  bit         req_taken;
  int         gap_pct;
  int         stall_pct;
  int         errors = 0;
  int         results_checked = 0;
  int         restarts_sent;
  int         goal_results = 0;
  int         settings_used;

  // car model: registers, state and the cosine table
  longint spd_lim, pos_lo, pos_hi, goal;
  longint px, py, vx, vy;
  longint cos_lut [COS_N];

  function automatic longint cos_point(int i);
    int unsigned divs[4];
    logic [63:0] f, x, x2, t;
    longint      c;
    bit          neg;
    divs = '{90, 56, 30, 12};
    f    = (64'(i) << 32) / COS_N;
    neg  = 1'b0;
    if (f > 64'h8000_0000) f = 64'h1_0000_0000 - f;
    if (f > 64'h4000_0000) begin
      f   = 64'h8000_0000 - f;
      neg = 1'b1;
    end
    x  = (f * TWO_PI_30) >> 32;
    x2 = (x * x) >> 30;
    t  = ONE_30;
    for (int k = 0; k < 4; k++) t = ONE_30 - ((x2 * t) >> 30) / divs[k];
    c = longint'(ONE_30) - longint'(((x2 * t) >> 30) / 2);
    if (c < 0) c = 0;
    c = (c + (longint'(1) << (29 - FB))) >>> (30 - FB);
    return neg ? -c : c;
  endfunction

  function automatic longint cos_of_triple_pos(longint p);
    logic [63:0] prod, ph;
    prod = p * TURN_K;
    ph   = (prod >> FB) & 64'hFFFF_FFFF;
    return cos_lut[ph[31 -: $clog2(COS_N)]];
  endfunction

  function automatic longint axis_accel(longint p, int dir);
    longint      push, c, g;
    logic [63:0] mag;
    push = longint'((PUSH_32 + (64'd1 << (31 - FB))) >> (32 - FB));
    c    = cos_of_triple_pos(p);
    mag  = (c < 0) ? -c : c;
    g    = longint'((mag * GRAV_32 + 64'h8000_0000) >> 32);
    return (c >= 0) ? dir * push - g : dir * push + g;
  endfunction

  task automatic clamp_axis(inout longint p, inout longint v);
    longint q;
    if (v > spd_lim) v = spd_lim;
    else if (v < -spd_lim) v = -spd_lim;
    q = p + v;
    if (q > pos_hi) q = pos_hi;
    if (q < pos_lo) q = pos_lo;
    if (q == pos_hi && v > 0) v = 0;
    if (q == pos_lo && v < 0) v = 0;
    p = q;
  endtask

  task automatic restart_car();
    px = -(longint'(1) << (FB - 1));
    py = -(longint'(1) << (FB - 1));
    vx = 0;
    vy = 0;
  endtask

  task automatic advance_car(input car_req_t r, output car_state_t s);
    int dx, dy;
    if (r.kind == REQ_RESTART) begin
      restart_car();
    end else begin
      if (r.act <= ACT_Y_POS) begin
        dx = (r.act == ACT_X_NEG) ? -1 : (r.act == ACT_X_POS) ? 1 : 0;
        dy = (r.act == ACT_Y_NEG) ? -1 : (r.act == ACT_Y_POS) ? 1 : 0;
        vx += axis_accel(px, dx);
        vy += axis_accel(py, dy);
      end
      clamp_axis(px, vx);
      clamp_axis(py, vy);
    end
    s.pos_x   = POS_W'(px);
    s.pos_y   = POS_W'(py);
    s.vel_x   = POS_W'(vx);
    s.vel_y   = POS_W'(vy);
    s.at_goal = (px >= goal) && (py >= goal);
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // request driver and response ready, both at the falling edge
  always @(negedge clk) begin
    car_req_t beat;
    if (rst) begin
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_STEP;
      req_bus.action   <= ACT_NONE;
      rsp_bus.ready    <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      if (!req_bus.valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
          beat = pending_reqs.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.req_type <= beat.kind;
          req_bus.action   <= beat.act;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: register writes, accepted requests and result beats
  always @(posedge clk) begin
    car_req_t   r;
    car_state_t want;
    if (rst) begin
      req_taken <= 1'b0;
      spd_lim = 4588;
      pos_lo  = -78643;
      pos_hi  = 39322;
      goal    = 32768;
      restart_car();
    end else begin
      req_taken <= req_bus.valid && req_bus.ready;
      if (cfg_we) begin
        case (hcd_cfg_idx_t'(cfg_idx))
          CFG_MAX_SPEED:   spd_lim = longint'(cfg_wdata[SPD_W-1:0]);
          CFG_LOWER_BOUND: pos_lo  = longint'($signed(cfg_wdata));
          CFG_UPPER_BOUND: pos_hi  = longint'($signed(cfg_wdata));
          CFG_GOAL_LEVEL:  goal    = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (req_bus.valid && req_bus.ready) begin
        r.kind = hcd_req_type_t'(req_bus.req_type);
        r.act  = req_bus.action;
        advance_car(r, want);
        expected_states.push_back(want);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_states.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = expected_states.pop_front();
          check_field("pos_x", want.pos_x, rsp_bus.pos_x);
          check_field("pos_y", want.pos_y, rsp_bus.pos_y);
          check_field("vel_x", want.vel_x, rsp_bus.vel_x);
          check_field("vel_y", want.vel_y, rsp_bus.vel_y);
          check_field("at_goal", want.at_goal, rsp_bus.at_goal);
          results_checked++;
          if (want.at_goal) goal_results++;
        end
      end
    end
  end

  task automatic push_req(hcd_req_type_t kind, logic [2:0] act);
    car_req_t r;
    r.kind = kind;
    r.act  = act;
    pending_reqs.push_back(r);
    if (kind == REQ_RESTART) restarts_sent++;
  endtask

  task automatic write_reg(hcd_cfg_idx_t idx, logic [POS_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  task automatic apply_settings(logic [POS_W-1:0] ms, logic [POS_W-1:0] lo,
                                logic [POS_W-1:0] hi, logic [POS_W-1:0] gl);
    write_reg(CFG_MAX_SPEED, ms);
    write_reg(CFG_LOWER_BOUND, lo);
    write_reg(CFG_UPPER_BOUND, hi);
    write_reg(CFG_GOAL_LEVEL, gl);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(idle_mode_t mode);
    @(posedge clk);
    gap_pct   = (mode == IDLE_SEND) ? 69 : (mode == IDLE_BOTH) ? 16 : 0;
    stall_pct = (mode == IDLE_RECV) ? 69 : (mode == IDLE_BOTH) ? 16 : 0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_bus.valid || expected_states.size() != 0)
      @(posedge clk);
  endtask

  // mostly held pushes of random length, some restarts and unknown actions
  task automatic run_phase(idle_mode_t mode, int n);
    int         run_left;
    int         pick;
    logic [2:0] held;
    run_left = 0;
    held     = ACT_NONE;
    set_idling(mode);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_req(REQ_RESTART, 3'($urandom_range(ACT_BAD_HI)));
      end else if (pick < 8) begin
        push_req(REQ_STEP, 3'($urandom_range(ACT_BAD_HI, ACT_BAD_LO)));
      end else begin
        if (run_left == 0) begin
          held     = 3'($urandom_range(ACT_Y_POS));
          run_left = $urandom_range(40, 1);
        end
        push_req(REQ_STEP, held);
        run_left--;
      end
    end
    drain();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_MAX_SPEED;
    cfg_wdata        = '0;
    gap_pct          = 0;
    stall_pct        = 0;
    restarts_sent    = 0;
    settings_used    = 1;
    for (int i = 0; i < COS_N; i++) cos_lut[i] = cos_point(i);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every action, unknown actions, restart ignoring its action
    set_idling(IDLE_NONE);
    push_req(REQ_RESTART, ACT_BAD_HI);
    push_req(REQ_STEP, ACT_NONE);
    push_req(REQ_STEP, ACT_X_NEG);
    push_req(REQ_STEP, ACT_X_POS);
    push_req(REQ_STEP, ACT_Y_NEG);
    push_req(REQ_STEP, ACT_Y_POS);
    push_req(REQ_STEP, ACT_BAD_LO);
    push_req(REQ_STEP, 3'(ACT_BAD_LO + 1));
    push_req(REQ_STEP, ACT_BAD_HI);
    repeat (10) push_req(REQ_STEP, ACT_X_POS);
    repeat (5) push_req(REQ_STEP, ACT_Y_NEG);
    push_req(REQ_RESTART, ACT_NONE);
    drain();

    apply_settings(POS_W'(4588), POS_W'(-78643), POS_W'(39322), POS_W'(32768));
    run_phase(IDLE_NONE, 240);
    // widest limits; bit 17 of the speed write is dropped
    apply_settings(POS_W'(18'h3FFFF), POS_W'(-131072), POS_W'(131071), POS_W'(-131072));
    run_phase(IDLE_SEND, 240);
    // crossed bounds: position pinned at the lower bound
    apply_settings(POS_W'(2000), POS_W'(20000), POS_W'(-20000), POS_W'(131071));
    run_phase(IDLE_RECV, 160);
    apply_settings(POS_W'(0), POS_W'(-131072), POS_W'(131071), POS_W'(0));
    run_phase(IDLE_BOTH, 80);
    // low goal so at_goal toggles often
    apply_settings(POS_W'(8000), POS_W'(-60000), POS_W'(60000), POS_W'(-40000));
    run_phase(IDLE_NONE, 240);
    for (int k = 0; k < 3; k++) begin
      apply_settings(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      run_phase(idle_mode_t'((k + 1) % 4), 240);
    end
    apply_settings(POS_W'(4588), POS_W'(-78643), POS_W'(39322), POS_W'(-32768));
    run_phase(IDLE_BOTH, 200);

    repeat (20) @(posedge clk);
    $display("Checked %0d result beats (%0d restarts, %0d at goal) under %0d register settings",
             results_checked, restarts_sent, goal_results, settings_used);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still expected", expected_states.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
